>>> sv/sha1_pkg.sv
package sha1_pkg;

  localparam int unsigned IN_QUEUE_DEPTH  = 4;
  localparam int unsigned OUT_QUEUE_DEPTH = 8;

  localparam int unsigned DIGEST_WORDS = 5;
  localparam int unsigned ROUNDS       = 80;

  localparam logic [31:0] K_CH  = 32'h5A827999;
  localparam logic [31:0] K_PA1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_MAJ = 32'h8F1BBCDC;
  localparam logic [31:0] K_PA2 = 32'hCA62C1D6;

  localparam logic [31:0] H_INIT [DIGEST_WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [7:0] PAD_MARK = 8'h80;

  // one queued operation from the front end
  typedef struct packed {
    logic       has_byte;
    logic       ends_msg;
    logic [7:0] data;
  } op_t;

  // one digest word headed for the result queue
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } res_t;

endpackage

>>> sv/sha1_fifo.sv
module sha1_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  // depth is a power of two, at least two
  localparam int unsigned AddrW = $clog2(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [AddrW:0]   wr_q, wr_d;
  logic [AddrW:0]   rd_q, rd_d;
  logic             do_push, do_pop;

  assign full_o  = (wr_q[AddrW] != rd_q[AddrW]) &&
                   (wr_q[AddrW-1:0] == rd_q[AddrW-1:0]);
  assign empty_o = (wr_q == rd_q);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q[AddrW-1:0]];

  always_comb begin
    wr_d = wr_q;
    rd_d = rd_q;
    if (do_push) begin
      wr_d = wr_q + {{AddrW{1'b0}}, 1'b1};
    end
    if (do_pop) begin
      rd_d = rd_q + {{AddrW{1'b0}}, 1'b1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q[AddrW-1:0]] <= data_i;
    end
  end

endmodule

>>> sv/sha1_front.sv
module sha1_front #(
  parameter int unsigned Depth = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  output logic            full_o,
  input  logic [7:0]      message_byte_i,
  input  logic            byte_present_i,
  input  logic            final_item_i,
  output sha1_pkg::op_t   op_o,
  output logic            op_valid_o,
  input  logic            op_pop_i
);
  import sha1_pkg::*;

  op_t  op_in;
  logic keep;
  logic op_empty;

  // items with no byte and no end mark change nothing: drop them here
  assign keep = byte_present_i || final_item_i;

  always_comb begin
    op_in.has_byte = byte_present_i;
    op_in.ends_msg = final_item_i;
    op_in.data     = message_byte_i;
  end

  sha1_fifo #(
    .Width ($bits(op_t)),
    .Depth (Depth)
  ) u_op_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i && keep),
    .data_i  (op_in),
    .full_o  (full_o),
    .pop_i   (op_pop_i),
    .data_o  (op_o),
    .empty_o (op_empty)
  );

  assign op_valid_o = !op_empty;

endmodule

>>> sv/sha1_back.sv
module sha1_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sha1_pkg::op_t  op_i,
  input  logic           op_valid_i,
  output logic           op_pop_o,
  output sha1_pkg::res_t res_o,
  output logic           res_push_o,
  input  logic           res_full_i
);
  import sha1_pkg::*;

  typedef enum logic [4:0] {
    ST_LOAD  = 5'b00001,
    ST_PAD   = 5'b00010,
    ST_ROUND = 5'b00100,
    ST_ADD   = 5'b01000,
    ST_EMIT  = 5'b10000
  } st_e;

  st_e         state_q, state_d;
  logic [5:0]  fill_q, fill_d;
  logic [6:0]  round_q, round_d;
  logic [63:0] bits_q, bits_d;
  logic [31:0] h_q [DIGEST_WORDS];
  logic [31:0] h_d [DIGEST_WORDS];
  logic        pad_q, pad_d;
  logic        mark_q, mark_d;
  logic        len_q, len_d;
  logic        last_q, last_d;
  logic [2:0]  emit_q, emit_d;

  logic [23:0] acc_q;
  logic [31:0] w_q [16];
  logic [31:0] a_q, b_q, c_q, d_q, e_q;

  logic        ins_v;
  logic [7:0]  ins_b;
  logic [7:0]  pad_b;
  logic [7:0][7:0] len_bytes;
  logic [1:0]  phase;
  logic [31:0] f_v, k_v, t_v, w_new;
  logic        blk_done;

  assign len_bytes = bits_q;

  // padding byte: end mark, zeros, then the big-endian bit length
  always_comb begin
    if (!mark_q) begin
      pad_b = PAD_MARK;
    end else if (len_q && fill_q >= 6'd56) begin
      pad_b = len_bytes[~fill_q[2:0]];
    end else begin
      pad_b = 8'h00;
    end
  end

  always_comb begin
    ins_v = 1'b0;
    ins_b = pad_b;
    if (state_q == ST_LOAD) begin
      ins_v = op_valid_i && op_i.has_byte;
      ins_b = op_i.data;
    end else if (state_q == ST_PAD) begin
      ins_v = 1'b1;
    end
  end

  assign blk_done = ins_v && (fill_q == 6'd63);
  assign op_pop_o = (state_q == ST_LOAD) && op_valid_i;

  // round function
  always_comb begin
    if (round_q < 7'd20) begin
      phase = 2'd0;
    end else if (round_q < 7'd40) begin
      phase = 2'd1;
    end else if (round_q < 7'd60) begin
      phase = 2'd2;
    end else begin
      phase = 2'd3;
    end
    case (phase)
      2'd0: begin
        f_v = (b_q & c_q) | (~b_q & d_q);
        k_v = K_CH;
      end
      2'd1: begin
        f_v = b_q ^ c_q ^ d_q;
        k_v = K_PA1;
      end
      2'd2: begin
        f_v = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
        k_v = K_MAJ;
      end
      default: begin
        f_v = b_q ^ c_q ^ d_q;
        k_v = K_PA2;
      end
    endcase
    t_v = {a_q[26:0], a_q[31:27]} + f_v + e_q + k_v + w_q[0];
  end

  always_comb begin
    w_new = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
    w_new = {w_new[30:0], w_new[31]};
  end

  always_comb begin
    res_o.word  = h_q[emit_q];
    res_o.index = emit_q;
    res_o.last  = (emit_q == 3'(DIGEST_WORDS - 1));
  end
  assign res_push_o = (state_q == ST_EMIT);

  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    round_d = round_q;
    bits_d  = bits_q;
    h_d     = h_q;
    pad_d   = pad_q;
    mark_d  = mark_q;
    len_d   = len_q;
    last_d  = last_q;
    emit_d  = emit_q;

    if (ins_v) begin
      fill_d = fill_q + 6'd1;
    end

    case (state_q)
      ST_LOAD: begin
        if (op_valid_i) begin
          if (op_i.has_byte) begin
            bits_d = bits_q + 64'd8;
          end
          pad_d = op_i.ends_msg;
          if (blk_done) begin
            state_d = ST_ROUND;
            round_d = '0;
          end else if (op_i.ends_msg) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (!mark_q) begin
          mark_d = 1'b1;
          len_d  = (fill_q <= 6'd55);
        end
        if (blk_done) begin
          state_d = ST_ROUND;
          round_d = '0;
          if (len_q && mark_q) begin
            last_d = 1'b1;
          end else begin
            len_d = 1'b1;
          end
        end
      end
      ST_ROUND: begin
        round_d = round_q + 7'd1;
        if (round_q == 7'(ROUNDS - 1)) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        h_d[0] = h_q[0] + a_q;
        h_d[1] = h_q[1] + b_q;
        h_d[2] = h_q[2] + c_q;
        h_d[3] = h_q[3] + d_q;
        h_d[4] = h_q[4] + e_q;
        emit_d = '0;
        if (last_q) begin
          state_d = ST_EMIT;
        end else if (pad_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_LOAD;
        end
      end
      ST_EMIT: begin
        if (!res_full_i) begin
          emit_d = emit_q + 3'd1;
          if (emit_q == 3'(DIGEST_WORDS - 1)) begin
            // start over for the next message
            state_d = ST_LOAD;
            h_d     = H_INIT;
            bits_d  = '0;
            pad_d   = 1'b0;
            mark_d  = 1'b0;
            len_d   = 1'b0;
            last_d  = 1'b0;
            emit_d  = '0;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      fill_q  <= '0;
      round_q <= '0;
      bits_q  <= '0;
      h_q     <= H_INIT;
      pad_q   <= 1'b0;
      mark_q  <= 1'b0;
      len_q   <= 1'b0;
      last_q  <= 1'b0;
      emit_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      round_q <= round_d;
      bits_q  <= bits_d;
      h_q     <= h_d;
      pad_q   <= pad_d;
      mark_q  <= mark_d;
      len_q   <= len_d;
      last_q  <= last_d;
      emit_q  <= emit_d;
    end
  end

  // byte packer, schedule shift line and working variables
  always_ff @(posedge clk_i) begin
    if (ins_v) begin
      acc_q <= {acc_q[15:0], ins_b};
      if (fill_q[1:0] == 2'd3) begin
        for (int i = 0; i < 15; i++) begin
          w_q[i] <= w_q[i+1];
        end
        w_q[15] <= {acc_q, ins_b};
      end
    end else if (state_q == ST_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[15] <= w_new;
    end

    if (blk_done) begin
      a_q <= h_q[0];
      b_q <= h_q[1];
      c_q <= h_q[2];
      d_q <= h_q[3];
      e_q <= h_q[4];
    end else if (state_q == ST_ROUND) begin
      a_q <= t_v;
      b_q <= a_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      d_q <= c_q;
      e_q <= d_q;
    end
  end

endmodule

>>> sv/sha1_stream_hasher_top.sv
// channel  | handshake             | payload
// ---------+-----------------------+-------------------------------------------
// input    | push / full           | message_byte_i, byte_present_i, final_item_i
// result   | pop / empty           | digest_word_o, word_index_o, last_word_o
//
// message bytes are packed one per cycle; every 64th byte starts a compression of
// 80 rounds plus one chaining add, during which bytes wait in the input queue
// a final item adds the padding bytes, one or two compressions and the writes of
// the five digest words into the result queue
// reset clears the chaining words to the initial values and empties both queues
// a full result queue holds the digest writer; a full input queue shows as full
module sha1_stream_hasher_top #(
  parameter int unsigned InDepth  = sha1_pkg::IN_QUEUE_DEPTH,
  parameter int unsigned OutDepth = sha1_pkg::OUT_QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  message_byte_i,
  input  logic        byte_present_i,
  input  logic        final_item_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);
  import sha1_pkg::*;

  // front end to back end
  op_t  op;
  logic op_valid;
  logic op_pop;

  // back end to result queue
  res_t res_in;
  res_t res_out;
  logic res_push;
  logic res_full;

  // front: takes items, drops ones with no effect, queues the rest
  sha1_front #(
    .Depth (InDepth)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_o         (full),
    .message_byte_i (message_byte_i),
    .byte_present_i (byte_present_i),
    .final_item_i   (final_item_i),
    .op_o           (op),
    .op_valid_o     (op_valid),
    .op_pop_i       (op_pop)
  );

  // back: packing, padding, rounds and digest write-out
  sha1_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (op),
    .op_valid_i (op_valid),
    .op_pop_o   (op_pop),
    .res_o      (res_in),
    .res_push_o (res_push),
    .res_full_i (res_full)
  );

  // result queue, oldest digest word on the ports
  sha1_fifo #(
    .Width ($bits(res_t)),
    .Depth (OutDepth)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign digest_word_o = res_out.word;
  assign word_index_o  = res_out.index;
  assign last_word_o   = res_out.last;

endmodule

>>> tb/sha1_stream_hasher_top_tb.sv
module sha1_stream_hasher_top_tb;
  import sha1_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // generous ceiling on the whole run, in clock cycles
  localparam int unsigned CYCLE_LIMIT = 400000;
  // worst final item: 72 padding bytes, two compressions and five writes
  localparam int unsigned SETTLE_CYCLES = 300;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [7:0]  message_byte_i;
  logic        byte_present_i;
  logic        final_item_i;
  logic        empty;
  logic        pop;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_word_o;

  sha1_stream_hasher_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .message_byte_i (message_byte_i),
    .byte_present_i (byte_present_i),
    .final_item_i   (final_item_i),
    .empty          (empty),
    .pop            (pop),
    .digest_word_o  (digest_word_o),
    .word_index_o   (word_index_o),
    .last_word_o    (last_word_o)
  );

  // traffic shaping knobs, in percent of cycles
  int          send_idle_pct;
  int          pop_stall_pct;
  // cycles the result side should hold off, picked up by the pop driver
  int          hold_request;
  int          mismatch_count;
  int          message_items;
  int unsigned cycle_count;

  // own copy of the hashing state
  logic [31:0] chain_h [DIGEST_WORDS];
  logic [7:0]  blk_bytes [64];
  int          fill_level;
  logic [63:0] msg_bits;

  // digest words still owed by the block, oldest first
  res_t        digest_words_due [$];

  // ---------------------------------------------------------------------------
  // sha-1 model
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] rol32(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic void sha1_restart();
    for (int i = 0; i < DIGEST_WORDS; i++) chain_h[i] = H_INIT[i];
    for (int i = 0; i < 64; i++) blk_bytes[i] = 8'h00;
    fill_level = 0;
    msg_bits   = 64'd0;
  endfunction

  function automatic void sha1_compress();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++) begin
      w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
    end
    for (int i = 16; i < ROUNDS; i++) begin
      w[i] = rol32(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    end
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int i = 0; i < ROUNDS; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = K_CH;
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = K_PA1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K_MAJ;
      end else begin
        f = b ^ c ^ d;
        k = K_PA2;
      end
      t = rol32(a, 5) + f + e + k + w[i];
      e = d;
      d = c;
      c = rol32(b, 30);
      b = a;
      a = t;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endfunction

  function automatic void sha1_put(input logic [7:0] v);
    blk_bytes[fill_level & 63] = v;
    fill_level++;
  endfunction

  // advance the model by one accepted item, queue the digest on a final item
  function automatic void sha1_absorb_item(input logic [7:0] b, input logic present,
                                           input logic fin);
    if (present) begin
      sha1_put(b);
      msg_bits += 64'd8;
      if (fill_level >= 64) begin
        sha1_compress();
        fill_level = 0;
      end
    end
    if (!fin) return;
    sha1_put(PAD_MARK);
    // no room left for the length: pad out and compress an extra block
    if (fill_level > 56) begin
      while (fill_level < 64) sha1_put(8'h00);
      sha1_compress();
      fill_level = 0;
    end
    while (fill_level < 56) sha1_put(8'h00);
    for (int i = 0; i < 8; i++) sha1_put(msg_bits[8*(7-i) +: 8]);
    sha1_compress();
    for (int i = 0; i < DIGEST_WORDS; i++) begin
      digest_words_due.push_back(res_t'{word: chain_h[i], index: 3'(i),
                                        last: (i == DIGEST_WORDS - 1)});
    end
    sha1_restart();
  endfunction

  // ---------------------------------------------------------------------------
  // clock, watchdog
  // ---------------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // hard stop if the run hangs anywhere
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  // pop driver: random stalls, plus long hold-offs counted here
  initial begin : pop_driver
    int hold_left;
    hold_left = 0;
    pop = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99, 0) >= pop_stall_pct);
      end
    end
  end

  // every accepted digest word against the oldest one owed
  always @(posedge clk_i) begin : digest_check
    res_t want;
    if (rst_ni && pop && !empty) begin
      if (digest_words_due.size() == 0) begin
        $error("digest_word %h (word_index %0d) arrived with none pending",
               digest_word_o, word_index_o);
        mismatch_count++;
      end else begin
        want = digest_words_due.pop_front();
        if (digest_word_o !== want.word) begin
          $error("digest_word mismatch: expected %h, actual %h", want.word, digest_word_o);
          mismatch_count++;
        end
        if (word_index_o !== want.index) begin
          $error("word_index mismatch: expected %0d, actual %0d", want.index, word_index_o);
          mismatch_count++;
        end
        if (last_word_o !== want.last) begin
          $error("last_word mismatch: expected %0b, actual %0b", want.last, last_word_o);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // offer one item, with random idle cycles first; push stays high afterwards
  // so back-to-back items never lower and raise it in the same step
  task automatic send_item(input logic [7:0] b, input logic present, input logic fin);
    @(negedge clk_i);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push           <= 1'b1;
    message_byte_i <= b;
    byte_present_i <= present;
    final_item_i   <= fin;
    // accepted at the first rising edge with full low
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sha1_absorb_item(b, present, fin);
    if (present || fin) message_items++;
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    push <= 1'b0;
  endtask

  task automatic wait_for_digests();
    while (digest_words_due.size() != 0) @(posedge clk_i);
  endtask

  // one message of random bytes, with ignored items mixed in
  task automatic send_message(input int len, input bit end_on_byte, input int noise_pct);
    for (int i = 0; i < len; i++) begin
      while ($urandom_range(99, 0) < noise_pct) begin
        send_item(8'($urandom_range(255, 0)), 1'b0, 1'b0);
      end
      send_item(8'($urandom_range(255, 0)), 1'b1, end_on_byte && (i == len - 1));
    end
    // separate final item without a byte; also the only way to end an empty message
    if (!end_on_byte || len == 0) send_item(8'($urandom_range(255, 0)), 1'b0, 1'b1);
  endtask

  // short messages, empty ones included
  function automatic int pick_length();
    return $urandom_range(9, 0);
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // short fixed messages: empty, extreme bytes, ignored bytes, end with and without a byte
  task automatic test_known_messages();
    send_idle_pct = 0;
    pop_stall_pct = 0;
    // empty message
    send_item(8'h00, 1'b0, 1'b1);
    // "abc", final item carries the last byte
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    // single 0xff byte, ended by a final item whose byte is ignored
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'hff, 1'b0, 1'b1);
    // single zero byte on the final item
    send_item(8'h00, 1'b1, 1'b1);
    // ignored items only, then an empty final
    send_item(8'haa, 1'b0, 1'b0);
    send_item(8'h55, 1'b0, 1'b0);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h80, 1'b0, 1'b1);
    // two bytes with an ignored one in between
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h7f, 1'b0, 1'b0);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h01, 1'b0, 1'b1);
    stop_sending();
    wait_for_digests();
  endtask

  // final byte lands at offset 55: the length no longer fits, padding spills over
  task automatic test_block_boundaries();
    send_idle_pct = 0;
    pop_stall_pct = 0;
    send_message(56, 1'b1, 0);
    stop_sending();
    wait_for_digests();
  endtask

  task automatic random_phase(input int idle_pct, input int stall_pct, input int item_goal);
    int msgs;
    int start_items;
    msgs          = 0;
    start_items   = message_items;
    send_idle_pct = idle_pct;
    pop_stall_pct = stall_pct;
    while ((message_items - start_items) < item_goal || msgs < 1) begin
      send_message(pick_length(), 1'($urandom_range(1, 0)), 15);
      msgs++;
    end
  endtask

  // random messages through every idling pattern
  task automatic test_random_traffic();
    random_phase(0, 0, 3);
    random_phase(63, 0, 3);
    random_phase(0, 63, 3);
    random_phase(11, 11, 3);
    stop_sending();
    wait_for_digests();
  endtask

  // result side holds off while short messages keep coming: both queues fill
  task automatic test_result_backpressure();
    send_idle_pct = 0;
    pop_stall_pct = 0;
    hold_request  = 1500;
    for (int i = 0; i < 6; i++) begin
      send_message($urandom_range(3, 1), 1'($urandom_range(1, 0)), 0);
    end
    stop_sending();
    wait_for_digests();
  endtask

  // sender waits for every digest before the next message
  task automatic test_paused_sender();
    send_idle_pct = 11;
    pop_stall_pct = 11;
    for (int i = 0; i < 3; i++) begin
      send_message($urandom_range(6, 0), 1'($urandom_range(1, 0)), 10);
      stop_sending();
      wait_for_digests();
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni         = 1'b0;
    push           = 1'b0;
    message_byte_i = 8'h00;
    byte_present_i = 1'b0;
    final_item_i   = 1'b0;
    send_idle_pct  = 0;
    pop_stall_pct  = 0;
    hold_request   = 0;
    mismatch_count = 0;
    message_items  = 0;
    sha1_restart();

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_known_messages();
    test_block_boundaries();
    test_random_traffic();
    test_result_backpressure();
    test_paused_sender();

    // let any stray output show up before the verdict
    wait_for_digests();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && digest_words_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
